FILE: hdl/lztd_pkg.sv
// ----------------------------------------------------------------------------
// lztd_pkg
// Shared types and defaults for the lz77 token decompressor.
// ----------------------------------------------------------------------------
package lztd_pkg;

  localparam int HISTORY_DEPTH_DEF = 4096;
  localparam int MAX_MATCH_DEF     = 63;

  localparam int DATA_W = 8;
  localparam int DIST_W = 16;
  localparam int LEN_W  = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_COPY,
    S_TAIL,
    S_ERR
  } state_t;

  // one result beat from the sequencer to the output register
  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] data;
    logic              last;
    logic              err;
  } emit_t;

endpackage

FILE: hdl/lztd_ram.sv
// ----------------------------------------------------------------------------
// lztd_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lztd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/lztd_ctrl.sv
// ----------------------------------------------------------------------------
// lztd_ctrl
// Token sequencer: checks a token, walks the copy pointer through history
// RAM one byte a cycle while the slot is free, appends every produced byte.
// ----------------------------------------------------------------------------
module lztd_ctrl #(
  parameter int HISTORY_DEPTH = lztd_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_MATCH     = lztd_pkg::MAX_MATCH_DEF,
  localparam int AW           = $clog2(HISTORY_DEPTH),
  localparam int CW           = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_new_stream,
  input  logic                        in_is_match,
  input  logic [lztd_pkg::DIST_W-1:0] in_distance,
  input  logic [lztd_pkg::LEN_W-1:0]  in_match_len,
  input  logic [lztd_pkg::DATA_W-1:0] in_next_byte,
  input  logic                        slot_free,
  output lztd_pkg::emit_t             emit,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [lztd_pkg::DATA_W-1:0] ram_wdata,
  output logic [AW-1:0]               ram_raddr,
  input  logic [lztd_pkg::DATA_W-1:0] ram_rdata
);

  localparam int SW = 18;
  localparam logic [SW-1:0] DEPTH_S = SW'(HISTORY_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(HISTORY_DEPTH - 1);
  localparam logic [lztd_pkg::LEN_W-1:0] MAX_L = lztd_pkg::LEN_W'(MAX_MATCH);

  lztd_pkg::state_t state_r, state_nxt;

  logic                        ns_r, ns_nxt;
  logic                        ism_r, ism_nxt;
  logic [lztd_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic [lztd_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [lztd_pkg::DATA_W-1:0] nb_r, nb_nxt;
  logic [AW-1:0]               wp_r, wp_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        err_r, err_nxt;
  logic [AW-1:0]               rp_r, rp_nxt;
  logic                        byp_r, byp_nxt;
  logic [lztd_pkg::DATA_W-1:0] byp_data_r, byp_data_nxt;

  logic [AW-1:0]               wp_eff;
  logic [CW-1:0]               cnt_eff;
  logic                        err_eff;
  logic                        bad;
  logic                        err_new;
  logic [SW-1:0]               rp_sum;
  logic [AW-1:0]               rp_start;
  logic [AW-1:0]               rp_inc;
  logic [AW-1:0]               wp_inc;
  logic                        consume;
  logic [lztd_pkg::DATA_W-1:0] copy_byte;

  // token check and copy start address
  always_comb begin
    wp_eff   = ns_r ? '0 : wp_r;
    cnt_eff  = ns_r ? '0 : cnt_r;
    err_eff  = ns_r ? 1'b0 : err_r;
    bad      = ism_r && ((dist_r == '0) || (SW'(dist_r) > SW'(cnt_eff)) || (len_r > MAX_L));
    err_new  = err_eff || bad;
    rp_sum   = SW'(wp_eff) + DEPTH_S - SW'(dist_r);
    rp_start = (rp_sum >= DEPTH_S) ? AW'(rp_sum - DEPTH_S) : AW'(rp_sum);
    rp_inc   = (rp_r == LAST_A) ? '0 : rp_r + AW'(1);
    wp_inc   = (wp_r == LAST_A) ? '0 : wp_r + AW'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lztd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = lztd_pkg::S_CHECK;
        end
      end
      lztd_pkg::S_CHECK: begin
        if (err_new) begin
          state_nxt = lztd_pkg::S_ERR;
        end else if (ism_r && (len_r != '0)) begin
          state_nxt = lztd_pkg::S_COPY;
        end else begin
          state_nxt = lztd_pkg::S_TAIL;
        end
      end
      lztd_pkg::S_COPY: begin
        if (slot_free && (len_r == lztd_pkg::LEN_W'(1))) begin
          state_nxt = lztd_pkg::S_TAIL;
        end
      end
      lztd_pkg::S_TAIL: begin
        if (slot_free) begin
          state_nxt = lztd_pkg::S_IDLE;
        end
      end
      lztd_pkg::S_ERR: begin
        if (slot_free) begin
          state_nxt = lztd_pkg::S_IDLE;
        end
      end
      default: state_nxt = lztd_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    consume   = 1'b0;
    copy_byte = byp_r ? byp_data_r : ram_rdata;
    emit      = '0;
    ram_raddr = rp_r;
    case (state_r)
      lztd_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      lztd_pkg::S_CHECK: begin
        ram_raddr = rp_start;
      end
      lztd_pkg::S_COPY: begin
        consume   = slot_free;
        emit.data = copy_byte;
        if (slot_free) begin
          ram_raddr = rp_inc;
        end
      end
      lztd_pkg::S_TAIL: begin
        consume   = slot_free;
        emit.data = nb_r;
        emit.last = 1'b1;
      end
      lztd_pkg::S_ERR: begin
        consume   = slot_free;
        emit.last = 1'b1;
        emit.err  = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    emit.vld  = consume;
    ram_we    = consume && (state_r != lztd_pkg::S_ERR);
    ram_waddr = wp_r;
    ram_wdata = emit.data;
  end

  // datapath next values
  always_comb begin
    ns_nxt       = ns_r;
    ism_nxt      = ism_r;
    dist_nxt     = dist_r;
    len_nxt      = len_r;
    nb_nxt       = nb_r;
    wp_nxt       = wp_r;
    cnt_nxt      = cnt_r;
    err_nxt      = err_r;
    rp_nxt       = rp_r;
    byp_nxt      = 1'b0;
    byp_data_nxt = copy_byte;
    if ((state_r == lztd_pkg::S_IDLE) && in_valid) begin
      ns_nxt   = in_new_stream;
      ism_nxt  = in_is_match;
      dist_nxt = in_distance;
      len_nxt  = in_match_len;
      nb_nxt   = in_next_byte;
    end
    if (state_r == lztd_pkg::S_CHECK) begin
      wp_nxt  = wp_eff;
      cnt_nxt = cnt_eff;
      err_nxt = err_new;
      rp_nxt  = rp_start;
    end
    if ((state_r == lztd_pkg::S_COPY) && consume) begin
      // read of the byte being written this cycle comes from the bypass
      byp_nxt = (rp_inc == wp_r);
      rp_nxt  = rp_inc;
      len_nxt = len_r - lztd_pkg::LEN_W'(1);
    end
    if (ram_we) begin
      wp_nxt  = wp_inc;
      cnt_nxt = (cnt_r == DEPTH_C) ? cnt_r : cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lztd_pkg::S_IDLE;
      wp_r    <= '0;
      cnt_r   <= '0;
      err_r   <= 1'b0;
      byp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      byp_r   <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ns_r       <= ns_nxt;
    ism_r      <= ism_nxt;
    dist_r     <= dist_nxt;
    len_r      <= len_nxt;
    nb_r       <= nb_nxt;
    rp_r       <= rp_nxt;
    byp_data_r <= byp_data_nxt;
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit.vld |-> slot_free) else $error("result emitted into a full output register");

  a_write_only_good: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (emit.vld && !emit.err)) else $error("history written without a good result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("produced count above history depth");

  a_copy_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == lztd_pkg::S_COPY) |-> ($past(state_r) == lztd_pkg::S_CHECK) && !err_r)
    else $error("copy entered without a passing check");

endmodule

FILE: hdl/lz77_token_decompressor.sv
// ----------------------------------------------------------------------------
// lz77_token_decompressor
// LZ77 token decompressor: turns literal and match tokens into output bytes.
// ----------------------------------------------------------------------------
// usage
//   in_*  : one token per transaction (valid/ready). new_stream restarts the
//           history window and clears a sticky error before the token.
//   out_* : one byte per transaction; out_last marks the final byte of a
//           token, out_error marks the single result of a bad token or of
//           any token while the stream is in error.
//   a token is taken only while the sequencer is idle. after acceptance the
//   check state checks it, then one byte is produced per cycle through the
//   history RAM read port while the output register has room; the next
//   token is taken only after the last result of this one has been handed
//   to the output register.
//   reset clears the write pointer, byte count and error flag; history RAM
//   contents are not cleared and are never output before being written.
//   when out_ready is low with the output register full, the sequencer holds
//   its place and resumes without loss; the finished byte waits there meanwhile.
// ----------------------------------------------------------------------------
module lz77_token_decompressor #(
  parameter int HISTORY_DEPTH = lztd_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_MATCH     = lztd_pkg::MAX_MATCH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_new_stream,
  input  logic                        in_is_match,
  input  logic [lztd_pkg::DIST_W-1:0] in_distance,
  input  logic [lztd_pkg::LEN_W-1:0]  in_match_len,
  input  logic [lztd_pkg::DATA_W-1:0] in_next_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lztd_pkg::DATA_W-1:0] out_data_byte,
  output logic                        out_last,
  output logic                        out_error
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  lztd_pkg::emit_t             emit;
  logic                        slot_free;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [lztd_pkg::DATA_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [lztd_pkg::DATA_W-1:0] ram_rdata;

  logic                        out_valid_r, out_valid_nxt;
  logic [lztd_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_err_r, out_err_nxt;

  lztd_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_MATCH     (MAX_MATCH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_new_stream   (in_new_stream),
    .in_is_match     (in_is_match),
    .in_distance     (in_distance),
    .in_match_len    (in_match_len),
    .in_next_byte    (in_next_byte),
    .slot_free       (slot_free),
    .emit            (emit),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  lztd_ram #(
    .WIDTH (lztd_pkg::DATA_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  always_comb begin
    slot_free     = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    if (emit.vld) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit.data;
      out_last_nxt  = emit.last;
      out_err_nxt   = emit.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_data_r;
  assign out_last      = out_last_r;
  assign out_error     = out_err_r;

endmodule

FILE: tb/lztd_byte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lztd_byte_checker
// Watches both channels of the lz77 token decompressor. Each accepted token
// is expanded into the bytes it must produce, using a private history window.
// Each accepted output byte is compared against the oldest pending one.
// ----------------------------------------------------------------------------
module lztd_byte_checker #(
  parameter int HIST_DEPTH = lztd_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_LEN    = lztd_pkg::MAX_MATCH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_new_stream,
  input  logic                        in_is_match,
  input  logic [lztd_pkg::DIST_W-1:0] in_distance,
  input  logic [lztd_pkg::LEN_W-1:0]  in_match_len,
  input  logic [lztd_pkg::DATA_W-1:0] in_next_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [lztd_pkg::DATA_W-1:0] out_data_byte,
  input  logic                        out_last,
  input  logic                        out_error,
  output int                          fail_count,
  output int                          pending,
  output int                          tokens_seen,
  output int                          bytes_seen,
  output int                          errors_seen,
  output logic                        wrap_seen
);

  typedef struct packed {
    logic [lztd_pkg::DATA_W-1:0] data;
    logic                        last;
    logic                        err;
  } byte_beat_t;

  byte_beat_t                  beat_q[$];
  logic [lztd_pkg::DATA_W-1:0] hist_mem [HIST_DEPTH];
  int                          wr_ptr;
  int                          hist_fill;
  logic                        err_sticky;

  task automatic flag_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic append_byte(input logic [lztd_pkg::DATA_W-1:0] b, input logic is_last);
    hist_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    if (wr_ptr == 0) begin
      wrap_seen = 1'b1;
    end
    if (hist_fill < HIST_DEPTH) begin
      hist_fill++;
    end
    beat_q.insert(beat_q.size(), byte_beat_t'{data: b, last: is_last, err: 1'b0});
    pending++;
  endtask

  task automatic expand_token();
    int rd;
    int k;
    if (in_new_stream) begin
      wr_ptr     = 0;
      hist_fill  = 0;
      err_sticky = 1'b0;
    end
    if (!err_sticky && in_is_match && (in_distance == 0 || in_distance > hist_fill ||
        in_distance > HIST_DEPTH || in_match_len > MAX_LEN)) begin
      err_sticky = 1'b1;
    end
    tokens_seen++;
    if (err_sticky) begin
      beat_q.insert(beat_q.size(), byte_beat_t'{data: '0, last: 1'b1, err: 1'b1});
      pending++;
      return;
    end
    if (in_is_match) begin
      // copy source may overlap the bytes being written
      rd = (wr_ptr + HIST_DEPTH - in_distance) % HIST_DEPTH;
      for (k = 0; k < in_match_len; k++) begin
        append_byte(hist_mem[rd], 1'b0);
        rd = (rd + 1) % HIST_DEPTH;
      end
    end
    append_byte(in_next_byte, 1'b1);
  endtask

  task automatic check_beat();
    byte_beat_t want;
    if (beat_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected transaction data %02h last %b error %b",
                              out_data_byte, out_last, out_error));
      return;
    end
    want = beat_q.pop_front();
    pending--;
    if (want.err) begin
      errors_seen++;
    end else begin
      bytes_seen++;
    end
    if (out_data_byte !== want.data || out_last !== want.last || out_error !== want.err) begin
      flag_mismatch($sformatf("data %02h/%02h last %b/%b error %b/%b (got/exp)",
                              out_data_byte, want.data, out_last, want.last,
                              out_error, want.err));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      beat_q.delete();
      wr_ptr      = 0;
      hist_fill   = 0;
      err_sticky  = 1'b0;
      fail_count  = 0;
      pending     = 0;
      tokens_seen = 0;
      bytes_seen  = 0;
      errors_seen = 0;
      wrap_seen   = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_beat();
      end
      if (in_valid && in_ready) begin
        expand_token();
      end
    end
  end

endmodule

FILE: tb/tb_lz77_token_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz77_token_decompressor
// Drives literal and match tokens into the decompressor: directed corner
// tokens, a long stream that fills and wraps the history window, then random
// streams with valid and broken tokens under sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_lz77_token_decompressor;

  localparam int   DIST_W          = lztd_pkg::DIST_W;
  localparam int   LEN_W           = lztd_pkg::LEN_W;
  localparam int   DATA_W          = lztd_pkg::DATA_W;
  localparam int   HIST_DEPTH      = lztd_pkg::HISTORY_DEPTH_DEF;
  localparam int   MAX_LEN         = lztd_pkg::MAX_MATCH_DEF;
  localparam int   HOLD_OFF_CYCLES = 400;
  localparam int   DRAIN_CYCLES    = 10;
  localparam int   CYCLE_LIMIT     = 400000;
  localparam int   FILL_TOKENS     = 80;
  localparam int   RAND_TOKENS     = 6;
  localparam logic TOK_LITERAL     = 1'b0;
  localparam logic TOK_MATCH       = 1'b1;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_new_stream;
  logic              in_is_match;
  logic [DIST_W-1:0] in_distance;
  logic [LEN_W-1:0]  in_match_len;
  logic [DATA_W-1:0] in_next_byte;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_data_byte;
  logic              out_last;
  logic              out_error;

  int   fail_count;
  int   pending;
  int   tokens_seen;
  int   bytes_seen;
  int   errors_seen;
  logic wrap_seen;

  int   gap_pct;
  int   stall_pct;
  logic hold_off_req;
  int   cycle_cnt = 0;
  int   trk_bytes;
  logic trk_err;

  lz77_token_decompressor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_new_stream   (in_new_stream),
    .in_is_match     (in_is_match),
    .in_distance     (in_distance),
    .in_match_len    (in_match_len),
    .in_next_byte    (in_next_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_last        (out_last),
    .out_error       (out_error)
  );

  lztd_byte_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_new_stream   (in_new_stream),
    .in_is_match     (in_is_match),
    .in_distance     (in_distance),
    .in_match_len    (in_match_len),
    .in_next_byte    (in_next_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_last        (out_last),
    .out_error       (out_error),
    .fail_count      (fail_count),
    .pending         (pending),
    .tokens_seen     (tokens_seen),
    .bytes_seen      (bytes_seen),
    .errors_seen     (errors_seen),
    .wrap_seen       (wrap_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : rx_proc
    int   n;
    logic hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (n = 1; n < HOLD_OFF_CYCLES; n++) begin
          @(posedge clk);
        end
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic logic [DIST_W-1:0] valid_distance(input int reach);
    case ($urandom_range(0, 3))
      0:       return DIST_W'($urandom_range(1, (reach < 8) ? reach : 8));
      1:       return DIST_W'(reach);
      default: return DIST_W'($urandom_range(1, reach));
    endcase
  endfunction

  task automatic push_token(input logic ns, input logic m, input logic [DIST_W-1:0] tok_dist,
                            input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] nb);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid        <= 1'b1;
    in_new_stream   <= ns;
    in_is_match     <= m;
    in_distance     <= tok_dist;
    in_match_len    <= len;
    in_next_byte    <= nb;
    do @(posedge clk); while (!in_ready);
    // stream bookkeeping so later tokens can aim at valid distances
    if (ns) begin
      trk_bytes = 0;
      trk_err   = 1'b0;
    end
    if (!trk_err && m && (tok_dist == 0 || tok_dist > trk_bytes || len > MAX_LEN)) begin
      trk_err = 1'b1;
    end
    if (!trk_err) begin
      trk_bytes = trk_bytes + (m ? len : 0) + 1;
      if (trk_bytes > HIST_DEPTH) begin
        trk_bytes = HIST_DEPTH;
      end
    end
  endtask

  task automatic random_token();
    logic              ns;
    logic              m;
    logic [DIST_W-1:0] tok_dist;
    logic [LEN_W-1:0]  len;
    int                sel;
    int                reach;
    ns       = trk_err ? ($urandom_range(0, 9) < 6) : ($urandom_range(0, 99) < 5);
    reach    = ns ? 0 : trk_bytes;
    sel      = $urandom_range(0, 99);
    tok_dist = DIST_W'($urandom);
    len      = LEN_W'($urandom);
    m        = TOK_MATCH;
    if (sel < 20 || (sel < 85 && reach == 0)) begin
      m = TOK_LITERAL;
    end else if (sel < 85) begin
      tok_dist = valid_distance(reach);
      len      = LEN_W'($urandom_range(0, MAX_LEN));
    end else begin
      case ($urandom_range(0, 2))
        0:       tok_dist = '0;
        1:       tok_dist = DIST_W'($urandom_range(reach + 1, 65535));
        default: len      = LEN_W'($urandom_range(MAX_LEN + 1, 255));
      endcase
    end
    push_token(ns, m, tok_dist, len, DATA_W'($urandom));
  endtask

  initial begin : stim_proc
    int i;
    int ph;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_new_stream   = 1'b0;
    in_is_match     = 1'b0;
    in_distance     = '0;
    in_match_len    = '0;
    in_next_byte    = '0;
    gap_pct         = 0;
    stall_pct       = 0;
    hold_off_req    = 1'b0;
    trk_bytes       = 0;
    trk_err         = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed corner tokens
    push_token(1'b1, TOK_LITERAL, '0, '0, 8'h00);
    push_token(1'b0, TOK_LITERAL, '0, '0, 8'hff);
    push_token(1'b0, TOK_MATCH, 16'd1, 8'd0, 8'h5a);
    push_token(1'b0, TOK_MATCH, 16'd1, 8'd63, 8'ha5);
    push_token(1'b0, TOK_MATCH, 16'd3, 8'd10, 8'h3c);
    push_token(1'b0, TOK_LITERAL, 16'hffff, 8'hff, 8'h81);
    push_token(1'b0, TOK_MATCH, 16'd67, 8'd20, 8'h7e);
    push_token(1'b0, TOK_MATCH, 16'd0, 8'd4, 8'h12);
    push_token(1'b0, TOK_LITERAL, '0, '0, 8'h34);
    push_token(1'b1, TOK_LITERAL, '0, '0, 8'h11);
    push_token(1'b0, TOK_MATCH, 16'd2, 8'd1, 8'h56);
    push_token(1'b1, TOK_LITERAL, '0, '0, 8'h22);
    push_token(1'b0, TOK_LITERAL, '0, '0, 8'h33);
    push_token(1'b0, TOK_MATCH, 16'd2, 8'd64, 8'h78);
    push_token(1'b1, TOK_LITERAL, '0, '0, 8'h9a);
    push_token(1'b0, TOK_MATCH, 16'd1, 8'd255, 8'hbc);
    push_token(1'b1, TOK_LITERAL, '0, '0, 8'hde);
    push_token(1'b0, TOK_MATCH, 16'hffff, 8'd5, 8'hf0);
    push_token(1'b1, TOK_MATCH, 16'd1, 8'd3, 8'h0f);
    push_token(1'b1, TOK_LITERAL, '0, '0, 8'h44);

    // one long stream that fills the window and wraps the write pointer
    push_token(1'b1, TOK_LITERAL, DIST_W'($urandom), LEN_W'($urandom), DATA_W'($urandom));
    for (i = 1; i < FILL_TOKENS; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_token(1'b0, TOK_LITERAL, DIST_W'($urandom), LEN_W'($urandom),
                   DATA_W'($urandom));
      end else begin
        push_token(1'b0, TOK_MATCH, valid_distance(trk_bytes),
                   LEN_W'($urandom_range(56, MAX_LEN)), DATA_W'($urandom));
      end
    end
    push_token(1'b0, TOK_MATCH, DIST_W'(HIST_DEPTH), LEN_W'(MAX_LEN), DATA_W'($urandom));
    push_token(1'b0, TOK_MATCH, DIST_W'(HIST_DEPTH + 1), 8'd3, DATA_W'($urandom));

    // random streams under different idling patterns
    for (ph = 1; ph <= 3; ph++) begin
      case (ph)
        1: begin
          gap_pct   = 64;
          stall_pct = 0;
        end
        2: begin
          gap_pct      = 0;
          stall_pct    = 64;
          hold_off_req <= 1'b1;
        end
        default: begin
          gap_pct   = 36;
          stall_pct = 36;
        end
      endcase
      for (i = 0; i < RAND_TOKENS; i++) begin
        random_token();
      end
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("%0d tokens in, %0d data bytes and %0d error results checked",
             tokens_seen, bytes_seen, errors_seen);
    $display("history window wrapped: %s", wrap_seen ? "yes" : "no");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
